// ===== rtl/tni_pkg.sv =====
// Shared constants for the nearest-insertion tour builder.
package tni_pkg;

    // Widths of the fields on the command and result channels, and of the config word.
    localparam int CITY_W = 5;
    localparam int DIST_W = 16;
    localparam int CFG_W  = 6;

    // Counts reach the tour size itself, so they carry one bit more than a city.
    localparam int CNT_W = 6;

    // Longest tour the result channel can number.
    localparam int OUT_LIMIT = 32;

    // Command codes carried in the func field.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_START = 1'b1;

endpackage

// ===== rtl/tni_cmd_if.sv =====
// Command channel: matrix writes and tour start requests.
interface tni_cmd_if;
    import tni_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [CITY_W-1:0] row_city;
    logic [CITY_W-1:0] col_city;
    logic [DIST_W-1:0] distance;
    logic [CITY_W-1:0] start_city;

    modport source (
        output valid,
        output func,
        output row_city,
        output col_city,
        output distance,
        output start_city,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  row_city,
        input  col_city,
        input  distance,
        input  start_city,
        output ready
    );

endinterface

// ===== rtl/tni_tour_if.sv =====
// Result channel: one tour city per transfer.
interface tni_tour_if;
    import tni_pkg::*;

    logic              valid;
    logic              ready;
    logic [CITY_W-1:0] tour_position;
    logic [CITY_W-1:0] tour_city;
    logic              last;
    logic              bad_origin;

    modport source (
        output valid,
        output tour_position,
        output tour_city,
        output last,
        output bad_origin,
        input  ready
    );

    modport sink (
        input  valid,
        input  tour_position,
        input  tour_city,
        input  last,
        input  bad_origin,
        output ready
    );

endinterface

// ===== rtl/tni_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module tni_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tsp_nearest_insertion_tour.sv =====
// Nearest-insertion tour builder: a matrix write goes straight into the distance RAM,
// and a start request builds the tour from the stored distances, then streams it one
// city per transfer. The matrix sits in one RAM with one read per cycle, and the tour is
// kept as a circular list of successor links in a second RAM. A start first runs the
// nearest-city scan and seeding, then one insertion pass per remaining city; the single
// matrix read port sets the pace of each pass, since one distance is fetched per cycle
// while the link list is walked. After the last pass, state S_OUT_LOAD loads the first
// result, and results then leave at one per cycle while the sink keeps ready high. A
// start with an origin not below the city count returns one error result in the next
// cycle. No new command is taken until the last result of a start has transferred.
module tsp_nearest_insertion_tour #(
    parameter int MAX_CITIES  = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [tni_pkg::CFG_W-1:0] cfg_wr_data,
    tni_cmd_if.sink                cmd,
    tni_tour_if.source             tour
);
    import tni_pkg::*;

    // Cities that can take part in a tour, and their index width.
    localparam int LIMIT = (MAX_CITIES < OUT_LIMIT) ? MAX_CITIES : OUT_LIMIT;
    localparam int LB    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    // Matrix row and column index width.
    localparam int CB    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int SW    = WEIGHT_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEAR,
        S_NEAR_TAIL,
        S_SEED_A,
        S_SEED_B,
        S_SKIP,
        S_WALK,
        S_WALK_TAIL,
        S_CLOSE,
        S_INS_RD,
        S_INS_A,
        S_INS_B,
        S_OUT_LOAD,
        S_OUT
    } state_t;

    state_t                 state_reg,      state_next;
    logic [CFG_W-1:0]       node_count_reg, node_count_next;
    logic [LB-1:0]          origin_reg,     origin_next;
    logic [CNT_W-1:0]       scan_reg,       scan_next;
    logic [CNT_W-1:0]       step_reg,       step_next;
    logic [CNT_W-1:0]       count_reg,      count_next;
    logic                   have_reg,       have_next;
    logic [SW-1:0]          best_reg,       best_next;
    logic [LB-1:0]          pick_reg,       pick_next;
    logic [LB-1:0]          after_reg,      after_next;
    logic [WEIGHT_BITS-1:0] first_w_reg,    first_w_next;
    logic [WEIGHT_BITS-1:0] prev_w_reg,     prev_w_next;
    logic [LB-1:0]          prev_city_reg,  prev_city_next;
    logic                   rd_valid_reg,   rd_valid_next;
    logic                   rd_first_reg,   rd_first_next;
    logic [LB-1:0]          rd_city_reg,    rd_city_next;
    logic [LIMIT-1:0]       placed_reg,     placed_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [CITY_W-1:0]      out_pos_reg,    out_pos_next;
    logic [CITY_W-1:0]      out_city_reg,   out_city_next;
    logic                   out_last_reg,   out_last_next;
    logic                   out_bad_reg,    out_bad_next;

    logic [CNT_W-1:0]       n_eff;

    logic                   dist_we;
    logic [2*CB-1:0]        dist_waddr;
    logic [WEIGHT_BITS-1:0] dist_wdata;
    logic                   dist_re;
    logic [2*CB-1:0]        dist_raddr;
    logic [WEIGHT_BITS-1:0] dist_rdata;

    logic                   link_we;
    logic [LB-1:0]          link_waddr;
    logic [LB-1:0]          link_wdata;
    logic                   link_re;
    logic [LB-1:0]          link_raddr;
    logic [LB-1:0]          link_rdata;

    logic                   cand_valid;
    logic [SW-1:0]          cand_sum;
    logic [LB-1:0]          cand_from;
    logic [LB-1:0]          cand_pick;
    logic [LB-1:0]          walk_city;

    tni_ram #(
        .ADDR_W (2 * CB),
        .DATA_W (WEIGHT_BITS)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .re    (dist_re),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // Successor of each tour city; the list is circular through the origin.
    tni_ram #(
        .ADDR_W (LB),
        .DATA_W (LB)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    always_comb
    begin
        if (node_count_reg < CFG_W'(2))
        begin
            n_eff = CNT_W'(2);
        end
        else if (node_count_reg > CFG_W'(LIMIT))
        begin
            n_eff = CNT_W'(LIMIT);
        end
        else
        begin
            n_eff = CNT_W'(node_count_reg);
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign tour.valid         = out_valid_reg;
    assign tour.tour_position = out_pos_reg;
    assign tour.tour_city     = out_city_reg;
    assign tour.last          = out_last_reg;
    assign tour.bad_origin    = out_bad_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;
        origin_next     = origin_reg;
        scan_next       = scan_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        have_next       = have_reg;
        best_next       = best_reg;
        pick_next       = pick_reg;
        after_next      = after_reg;
        first_w_next    = first_w_reg;
        prev_w_next     = prev_w_reg;
        prev_city_next  = prev_city_reg;
        rd_valid_next   = 1'b0;
        rd_first_next   = 1'b0;
        rd_city_next    = rd_city_reg;
        placed_next     = placed_reg;
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_city_next   = out_city_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;

        dist_we    = 1'b0;
        dist_waddr = {CB'(cmd.row_city), CB'(cmd.col_city)};
        dist_wdata = WEIGHT_BITS'(cmd.distance);
        dist_re    = 1'b0;
        dist_raddr = {CB'(origin_reg), CB'(scan_reg[LB-1:0])};

        link_we    = 1'b0;
        link_waddr = pick_reg;
        link_wdata = origin_reg;
        link_re    = 1'b0;
        link_raddr = origin_reg;

        walk_city  = (step_reg == '0) ? origin_reg : link_rdata;

        cand_valid = 1'b0;
        cand_sum   = SW'(dist_rdata);
        cand_from  = prev_city_reg;
        cand_pick  = scan_reg[LB-1:0];

        // Distance returned from the read issued in the previous cycle.
        if (rd_valid_reg)
        begin
            if ((state_reg == S_NEAR) || (state_reg == S_NEAR_TAIL))
            begin
                cand_valid = (rd_city_reg != origin_reg);
                cand_sum   = SW'(dist_rdata);
                cand_pick  = rd_city_reg;
            end
            else
            begin
                prev_w_next    = dist_rdata;
                prev_city_next = rd_city_reg;
                if (rd_first_reg)
                begin
                    first_w_next = dist_rdata;
                end
                else
                begin
                    cand_valid = 1'b1;
                    cand_sum   = SW'(prev_w_reg) + SW'(dist_rdata);
                end
            end
        end

        // The closing edge runs from the last tour city back to the origin.
        if (state_reg == S_CLOSE)
        begin
            cand_valid = 1'b1;
            cand_sum   = SW'(prev_w_reg) + SW'(first_w_reg);
        end

        if (cand_valid && (!have_reg || (cand_sum < best_reg)))
        begin
            have_next  = 1'b1;
            best_next  = cand_sum;
            pick_next  = cand_pick;
            after_next = cand_from;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.func == FUNC_WRITE)
                    begin
                        dist_we = (int'(cmd.row_city) < MAX_CITIES) &&
                                  (int'(cmd.col_city) < MAX_CITIES);
                    end
                    else if (CNT_W'(cmd.start_city) >= n_eff)
                    begin
                        out_valid_next = 1'b1;
                        out_pos_next   = '0;
                        out_city_next  = '0;
                        out_last_next  = 1'b1;
                        out_bad_next   = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        origin_next              = LB'(cmd.start_city);
                        placed_next              = '0;
                        placed_next[LB'(cmd.start_city)] = 1'b1;
                        scan_next                = '0;
                        have_next                = 1'b0;
                        state_next               = S_NEAR;
                    end
                end
            end

            S_NEAR:
            begin
                dist_re       = 1'b1;
                rd_valid_next = 1'b1;
                rd_city_next  = scan_reg[LB-1:0];
                scan_next     = scan_reg + CNT_W'(1);
                if (scan_reg == n_eff - CNT_W'(1))
                begin
                    state_next = S_NEAR_TAIL;
                end
            end

            S_NEAR_TAIL:
            begin
                state_next = S_SEED_A;
            end

            S_SEED_A:
            begin
                link_we    = 1'b1;
                link_waddr = origin_reg;
                link_wdata = pick_reg;
                state_next = S_SEED_B;
            end

            S_SEED_B:
            begin
                link_we               = 1'b1;
                link_waddr            = pick_reg;
                link_wdata            = origin_reg;
                placed_next[pick_reg] = 1'b1;
                count_next            = CNT_W'(2);
                scan_next             = '0;
                have_next             = 1'b0;
                state_next            = (n_eff == CNT_W'(2)) ? S_OUT_LOAD : S_SKIP;
            end

            S_SKIP:
            begin
                if (scan_reg >= n_eff)
                begin
                    state_next = S_INS_RD;
                end
                else if (placed_reg[scan_reg[LB-1:0]])
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // Follow the links from the origin, one tour city per cycle.
                dist_re       = 1'b1;
                dist_raddr    = {CB'(walk_city), CB'(scan_reg[LB-1:0])};
                link_re       = 1'b1;
                link_raddr    = walk_city;
                rd_valid_next = 1'b1;
                rd_first_next = (step_reg == '0);
                rd_city_next  = walk_city;
                step_next     = step_reg + CNT_W'(1);
                if (step_reg == count_reg - CNT_W'(1))
                begin
                    state_next = S_WALK_TAIL;
                end
            end

            S_WALK_TAIL:
            begin
                state_next = S_CLOSE;
            end

            S_CLOSE:
            begin
                scan_next  = scan_reg + CNT_W'(1);
                state_next = S_SKIP;
            end

            S_INS_RD:
            begin
                link_re    = 1'b1;
                link_raddr = after_reg;
                state_next = S_INS_A;
            end

            S_INS_A:
            begin
                link_we    = 1'b1;
                link_waddr = pick_reg;
                link_wdata = link_rdata;
                state_next = S_INS_B;
            end

            S_INS_B:
            begin
                link_we               = 1'b1;
                link_waddr            = after_reg;
                link_wdata            = pick_reg;
                placed_next[pick_reg] = 1'b1;
                count_next            = count_reg + CNT_W'(1);
                scan_next             = '0;
                have_next             = 1'b0;
                if (count_reg + CNT_W'(1) == n_eff)
                begin
                    state_next = S_OUT_LOAD;
                end
                else
                begin
                    state_next = S_SKIP;
                end
            end

            S_OUT_LOAD:
            begin
                link_re        = 1'b1;
                link_raddr     = origin_reg;
                out_valid_next = 1'b1;
                out_pos_next   = '0;
                out_city_next  = CITY_W'(origin_reg);
                out_last_next  = (count_reg == CNT_W'(1));
                out_bad_next   = 1'b0;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                if (tour.ready)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        // The link read of the previous transfer holds the next city.
                        link_re       = 1'b1;
                        link_raddr    = link_rdata;
                        out_pos_next  = out_pos_reg + CITY_W'(1);
                        out_city_next = CITY_W'(link_rdata);
                        out_last_next = (CNT_W'(out_pos_reg) + CNT_W'(2) == count_reg);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CFG_W'(32);
            origin_reg     <= '0;
            scan_reg       <= '0;
            step_reg       <= '0;
            count_reg      <= '0;
            have_reg       <= 1'b0;
            best_reg       <= '0;
            pick_reg       <= '0;
            after_reg      <= '0;
            first_w_reg    <= '0;
            prev_w_reg     <= '0;
            prev_city_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_city_reg    <= '0;
            placed_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_city_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            origin_reg     <= origin_next;
            scan_reg       <= scan_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            have_reg       <= have_next;
            best_reg       <= best_next;
            pick_reg       <= pick_next;
            after_reg      <= after_next;
            first_w_reg    <= first_w_next;
            prev_w_reg     <= prev_w_next;
            prev_city_reg  <= prev_city_next;
            rd_valid_reg   <= rd_valid_next;
            rd_first_reg   <= rd_first_next;
            rd_city_reg    <= rd_city_next;
            placed_reg     <= placed_next;
            out_valid_reg  <= out_valid_next;
            out_pos_reg    <= out_pos_next;
            out_city_reg   <= out_city_next;
            out_last_reg   <= out_last_next;
            out_bad_reg    <= out_bad_next;
        end
    end

    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !tour.valid)
        else $error("command taken while a result is pending");

    a_origin_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP) |-> placed_reg[origin_reg])
        else $error("origin not marked placed during the search");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP) |-> (count_reg < n_eff))
        else $error("search running on a complete tour");

    a_pick_unplaced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_B) |-> (have_reg && !placed_reg[pick_reg]))
        else $error("inserting a city that is already in the tour");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (tour.valid && tour.ready && tour.last) |=> (state_reg == S_IDLE && !tour.valid))
        else $error("results continue after the last transfer");

endmodule
